FILE: rtl/obst_pkg.sv
// Shared types, constants and helpers for the optimal BST builder.
package obst_pkg;

  localparam int MAX_KEYS    = 32;
  localparam int WEIGHT_BITS = 16;
  localparam int WT_W        = 16;
  localparam int KEY_W       = $clog2(MAX_KEYS + 1);
  localparam int IDX_W       = $clog2(MAX_KEYS);
  localparam int TAB_AW      = 2 * IDX_W;
  localparam int TAB_DEPTH   = 1 << TAB_AW;
  localparam int WTAB_DEPTH  = MAX_KEYS + 1;
  localparam int STK_DEPTH   = MAX_KEYS + 2;
  localparam int STK_AW      = $clog2(STK_DEPTH);
  localparam int SP_W        = $clog2(STK_DEPTH + 1);
  localparam int STK_W       = 2 * KEY_W;
  localparam int COST_W      = 32;

  localparam logic [WT_W-1:0]   WT_MASK = WT_W'((64'd1 << WEIGHT_BITS) - 64'd1);
  localparam logic [COST_W-1:0] INT_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [WT_W-1:0] dummy_weight;
    logic [WT_W-1:0] key_weight;
    logic            last_item;
  } in_beat_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key_index;
    logic [COST_W-1:0] tree_cost;
    logic              last_result;
  } out_beat_t;

  // Interval (i, j), both 1-based, maps to row i-1 and column j-1.
  function automatic logic [TAB_AW-1:0] tab_addr(input logic [KEY_W-1:0] i,
                                                 input logic [KEY_W-1:0] j);
    logic [KEY_W-1:0] im;
    logic [KEY_W-1:0] jm;
    im = i - KEY_W'(1);
    jm = j - KEY_W'(1);
    return {im[IDX_W-1:0], jm[IDX_W-1:0]};
  endfunction

endpackage

FILE: rtl/obst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module obst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/obst_dp_unit.sv
// Shared adder and strict less-than compare for the sequencer's arithmetic steps.
module obst_dp_unit
  import obst_pkg::*;
(
  input  logic [COST_W-1:0] add_a,
  input  logic [COST_W-1:0] add_b,
  input  logic [COST_W-1:0] best,
  output logic [COST_W-1:0] sum,
  output logic              less
);

  assign sum  = add_a + add_b;
  assign less = (sum < best);

endmodule

FILE: rtl/optimal_bst_builder.sv
// Top level of the optimal binary search tree builder: sequencer and tables.
//
//  channel | direction | handshake             | beat
//  --------+-----------+-----------------------+--------------------------------
//  in_     | input     | in_valid / in_ready   | dummy_weight, key_weight, last
//  out_    | output    | out_valid / out_ready | key_index, tree_cost, last
//
// Loading takes one beat per cycle; in_ready is high only while loading.
// After the final beat the shared adder fills the tables: first the single-key
// intervals, then each larger interval, trying every candidate root in turn;
// each candidate root needs two reads of the single cost table port. The
// preorder walk then emits the keys and waits while out_ready stalls the
// output register.
// Reset (rst_n low at a clock edge) returns to loading with no result pending.
module optimal_bst_builder
  import obst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_beat
);

  typedef enum logic [19:0] {
    ST_LOAD      = 20'h00001,
    ST_BASE_RD   = 20'h00002,
    ST_BASE_ADD  = 20'h00004,
    ST_BASE_WR   = 20'h00008,
    ST_INT_RD    = 20'h00010,
    ST_INT_ADD   = 20'h00020,
    ST_INT_W     = 20'h00040,
    ST_K_RD      = 20'h00080,
    ST_K_LEFT    = 20'h00100,
    ST_K_RIGHT   = 20'h00200,
    ST_INT_WR    = 20'h00400,
    ST_WALK_INIT = 20'h00800,
    ST_WALK_COST = 20'h01000,
    ST_POP       = 20'h02000,
    ST_CHK       = 20'h04000,
    ST_ROOT      = 20'h08000,
    ST_EMIT      = 20'h10000,
    ST_PUSH_R    = 20'h20000,
    ST_PUSH_L    = 20'h40000,
    ST_DONE      = 20'h80000
  } state_t;

  // Sequencer registers.
  state_t            state_r,    state_nxt;
  logic [KEY_W-1:0]  cnt_r,      cnt_nxt;
  logic [KEY_W-1:0]  n_r,        n_nxt;
  logic [KEY_W-1:0]  i_r,        i_nxt;
  logic [KEY_W-1:0]  j_r,        j_nxt;
  logic [KEY_W-1:0]  k_r,        k_nxt;
  logic [KEY_W-1:0]  sz_r,       sz_nxt;
  logic [COST_W-1:0] acc_r,      acc_nxt;
  logic [COST_W-1:0] w_r,        w_nxt;
  logic [COST_W-1:0] best_r,     best_nxt;
  logic [KEY_W-1:0]  pick_r,     pick_nxt;
  logic [COST_W-1:0] tot_r,      tot_nxt;
  logic [SP_W-1:0]   sp_r,       sp_nxt;
  logic [KEY_W-1:0]  lo_r,       lo_nxt;
  logic [KEY_W-1:0]  hi_r,       hi_nxt;
  logic [KEY_W-1:0]  root_r,     root_nxt;
  logic              pend_v_r,   pend_v_nxt;
  logic [KEY_W-1:0]  pend_key_r, pend_key_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_beat_r, out_beat_nxt;

  // Memory ports.
  logic                 q_we, p_we, q_re, p_re;
  logic [KEY_W-1:0]     q_waddr, q_raddr, p_raddr;
  logic [WT_W-1:0]      q_wdata, p_wdata, q_rdata, p_rdata;
  logic                 w_we, w_re, c_we, c_re, r_re;
  logic [TAB_AW-1:0]    w_waddr, w_raddr, c_waddr, c_raddr, r_raddr;
  logic [COST_W-1:0]    w_wdata, w_rdata, c_wdata, c_rdata;
  logic [KEY_W-1:0]     r_wdata, r_rdata;
  logic                 s_we, s_re;
  logic [STK_AW-1:0]    s_waddr, s_raddr;
  logic [STK_W-1:0]     s_wdata, s_rdata;

  // Shared arithmetic unit.
  logic [COST_W-1:0] add_a, add_b, sum;
  logic              less;

  logic              in_acc;
  logic              out_free;
  logic              last_in;
  logic [KEY_W-1:0]  stk_lo, stk_hi;
  logic [SP_W-1:0]   sp_dec;

  assign in_ready  = (state_r == ST_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;
  assign out_free  = !out_valid_r || out_ready;
  assign last_in   = in_beat.last_item || (cnt_r == KEY_W'(MAX_KEYS));
  assign stk_lo    = s_rdata[STK_W-1:KEY_W];
  assign stk_hi    = s_rdata[KEY_W-1:0];
  assign sp_dec    = sp_r - SP_W'(1);

  obst_dp_unit u_unit (
    .add_a (add_a),
    .add_b (add_b),
    .best  (best_r),
    .sum   (sum),
    .less  (less)
  );

  // Operand selection for the shared adder, one pairing per arithmetic step.
  always_comb begin
    add_a = '0;
    add_b = '0;
    case (state_r)
      ST_BASE_ADD: begin
        add_a = COST_W'(q_rdata);
        add_b = COST_W'(p_rdata);
      end
      ST_BASE_WR, ST_INT_W: begin
        add_a = acc_r;
        add_b = COST_W'(q_rdata);
      end
      ST_INT_ADD: begin
        add_a = w_rdata;
        add_b = COST_W'(p_rdata);
      end
      ST_K_LEFT: begin
        add_a = w_r;
        add_b = (k_r > i_r) ? c_rdata : '0;
      end
      ST_K_RIGHT: begin
        add_a = acc_r;
        add_b = (k_r < j_r) ? c_rdata : '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    sz_nxt        = sz_r;
    acc_nxt       = acc_r;
    w_nxt         = w_r;
    best_nxt      = best_r;
    pick_nxt      = pick_r;
    tot_nxt       = tot_r;
    sp_nxt        = sp_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    root_nxt      = root_r;
    pend_v_nxt    = pend_v_r;
    pend_key_nxt  = pend_key_r;
    out_valid_nxt = out_valid_r;
    out_beat_nxt  = out_beat_r;

    q_we = 1'b0;  q_waddr = cnt_r;  q_wdata = in_beat.dummy_weight & WT_MASK;
    p_we = 1'b0;  p_wdata = (cnt_r == '0) ? '0 : (in_beat.key_weight & WT_MASK);
    q_re = 1'b0;  q_raddr = i_r;
    p_re = 1'b0;  p_raddr = i_r;
    w_we = 1'b0;  w_waddr = tab_addr(i_r, j_r);  w_wdata = sum;
    w_re = 1'b0;  w_raddr = tab_addr(i_r, j_r - KEY_W'(1));
    c_we = 1'b0;  c_waddr = tab_addr(i_r, j_r);  c_wdata = best_r;
    c_re = 1'b0;  c_raddr = tab_addr(i_r, k_r - KEY_W'(1));
    r_wdata = pick_r;
    r_re = 1'b0;  r_raddr = tab_addr(stk_lo, stk_hi);
    s_we = 1'b0;  s_waddr = sp_r[STK_AW-1:0];  s_wdata = {root_r + KEY_W'(1), hi_r};
    s_re = 1'b0;  s_raddr = sp_dec[STK_AW-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          q_we = 1'b1;
          p_we = 1'b1;
          if (!last_in) begin
            cnt_nxt = cnt_r + KEY_W'(1);
          end else begin
            cnt_nxt = '0;
            if (cnt_r == '0) begin
              tot_nxt    = '0;
              pend_v_nxt = 1'b0;
              state_nxt  = ST_DONE;
            end else begin
              n_nxt     = cnt_r;
              i_nxt     = KEY_W'(1);
              state_nxt = ST_BASE_RD;
            end
          end
        end
      end
      ST_BASE_RD: begin
        q_re      = 1'b1;
        q_raddr   = i_r - KEY_W'(1);
        p_re      = 1'b1;
        state_nxt = ST_BASE_ADD;
      end
      ST_BASE_ADD: begin
        acc_nxt   = sum;
        q_re      = 1'b1;
        state_nxt = ST_BASE_WR;
      end
      ST_BASE_WR: begin
        w_we    = 1'b1;
        w_waddr = tab_addr(i_r, i_r);
        c_we    = 1'b1;
        c_waddr = tab_addr(i_r, i_r);
        c_wdata = sum;
        r_wdata = i_r;
        if (i_r == n_r) begin
          if (n_r == KEY_W'(1)) begin
            state_nxt = ST_WALK_INIT;
          end else begin
            sz_nxt    = KEY_W'(2);
            i_nxt     = KEY_W'(1);
            j_nxt     = KEY_W'(2);
            state_nxt = ST_INT_RD;
          end
        end else begin
          i_nxt     = i_r + KEY_W'(1);
          state_nxt = ST_BASE_RD;
        end
      end
      ST_INT_RD: begin
        w_re      = 1'b1;
        q_re      = 1'b1;
        q_raddr   = j_r;
        p_re      = 1'b1;
        p_raddr   = j_r;
        state_nxt = ST_INT_ADD;
      end
      ST_INT_ADD: begin
        acc_nxt   = sum;
        state_nxt = ST_INT_W;
      end
      ST_INT_W: begin
        w_nxt     = sum;
        w_we      = 1'b1;
        best_nxt  = INT_MAX;
        pick_nxt  = '0;
        k_nxt     = i_r;
        state_nxt = ST_K_RD;
      end
      ST_K_RD: begin
        c_re      = 1'b1;
        state_nxt = ST_K_LEFT;
      end
      ST_K_LEFT: begin
        acc_nxt   = sum;
        c_re      = 1'b1;
        c_raddr   = tab_addr(k_r + KEY_W'(1), j_r);
        state_nxt = ST_K_RIGHT;
      end
      ST_K_RIGHT: begin
        if (less) begin
          best_nxt = sum;
          pick_nxt = k_r;
        end
        if (k_r == j_r) begin
          state_nxt = ST_INT_WR;
        end else begin
          k_nxt     = k_r + KEY_W'(1);
          state_nxt = ST_K_RD;
        end
      end
      ST_INT_WR: begin
        c_we = 1'b1;
        if (j_r == n_r) begin
          if (sz_r == n_r) begin
            state_nxt = ST_WALK_INIT;
          end else begin
            sz_nxt    = sz_r + KEY_W'(1);
            i_nxt     = KEY_W'(1);
            j_nxt     = sz_r + KEY_W'(1);
            state_nxt = ST_INT_RD;
          end
        end else begin
          i_nxt     = i_r + KEY_W'(1);
          j_nxt     = j_r + KEY_W'(1);
          state_nxt = ST_INT_RD;
        end
      end
      ST_WALK_INIT: begin
        c_re       = 1'b1;
        c_raddr    = tab_addr(KEY_W'(1), n_r);
        s_we       = 1'b1;
        s_waddr    = '0;
        s_wdata    = {KEY_W'(1), n_r};
        sp_nxt     = SP_W'(1);
        pend_v_nxt = 1'b0;
        state_nxt  = ST_WALK_COST;
      end
      ST_WALK_COST: begin
        tot_nxt   = c_rdata;
        state_nxt = ST_POP;
      end
      ST_POP: begin
        if (sp_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          sp_nxt    = sp_dec;
          s_re      = 1'b1;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if ((stk_lo > stk_hi) || (stk_lo == '0) || (stk_hi > n_r)) begin
          state_nxt = ST_POP;
        end else begin
          lo_nxt    = stk_lo;
          hi_nxt    = stk_hi;
          r_re      = 1'b1;
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (r_rdata == '0) begin
          state_nxt = ST_POP;
        end else begin
          root_nxt  = r_rdata;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // The newest key is held back so the final one can carry last_result.
        if (!pend_v_r) begin
          pend_v_nxt   = 1'b1;
          pend_key_nxt = root_r;
          state_nxt    = ST_PUSH_R;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_beat_nxt  = '{key_index: pend_key_r, tree_cost: tot_r, last_result: 1'b0};
          pend_key_nxt  = root_r;
          state_nxt     = ST_PUSH_R;
        end
      end
      ST_PUSH_R: begin
        if ((sp_r + SP_W'(2)) <= SP_W'(STK_DEPTH)) begin
          s_we      = 1'b1;
          sp_nxt    = sp_r + SP_W'(1);
          state_nxt = ST_PUSH_L;
        end else begin
          state_nxt = ST_POP;
        end
      end
      ST_PUSH_L: begin
        s_we      = 1'b1;
        s_wdata   = {lo_r, root_r - KEY_W'(1)};
        sp_nxt    = sp_r + SP_W'(1);
        state_nxt = ST_POP;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_beat_nxt  = '{key_index: pend_v_r ? pend_key_r : '0,
                            tree_cost: tot_r, last_result: 1'b1};
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers carry no reset; control decides when they are used.
  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    sz_r       <= sz_nxt;
    acc_r      <= acc_nxt;
    w_r        <= w_nxt;
    best_r     <= best_nxt;
    pick_r     <= pick_nxt;
    tot_r      <= tot_nxt;
    sp_r       <= sp_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    root_r     <= root_nxt;
    pend_key_r <= pend_key_nxt;
    out_beat_r <= out_beat_nxt;
  end

  // Gap weights q[t] and key weights p[t].
  obst_ram #(.WIDTH(WT_W), .DEPTH(WTAB_DEPTH)) u_q_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .re(q_re), .raddr(q_raddr), .rdata(q_rdata)
  );

  obst_ram #(.WIDTH(WT_W), .DEPTH(WTAB_DEPTH)) u_p_ram (
    .clk(clk), .we(p_we), .waddr(q_waddr), .wdata(p_wdata),
    .re(p_re), .raddr(p_raddr), .rdata(p_rdata)
  );

  // Interval tables, indexed by (i-1, j-1).
  obst_ram #(.WIDTH(COST_W), .DEPTH(TAB_DEPTH)) u_w_ram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .re(w_re), .raddr(w_raddr), .rdata(w_rdata)
  );

  obst_ram #(.WIDTH(COST_W), .DEPTH(TAB_DEPTH)) u_c_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .re(c_re), .raddr(c_raddr), .rdata(c_rdata)
  );

  obst_ram #(.WIDTH(KEY_W), .DEPTH(TAB_DEPTH)) u_r_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(r_wdata),
    .re(r_re), .raddr(r_raddr), .rdata(r_rdata)
  );

  // Interval stack for the preorder walk.
  obst_ram #(.WIDTH(STK_W), .DEPTH(STK_DEPTH)) u_stk_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .re(s_re), .raddr(s_raddr), .rdata(s_rdata)
  );

endmodule

FILE: rtl/obst_checker.sv
// Port-level assertions for the optimal BST builder, bound to the top level.
module obst_checker
  import obst_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_beat_t  in_beat,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_beat
);

  // A stalled result beat holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_beat))
    else $error("result beat changed while stalled");

  // A result without a key only ever closes a run.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_beat.key_index == '0) |-> out_beat.last_result)
    else $error("empty key on a beat that is not the last");

  // Key indices stay within the key range.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_beat.key_index <= KEY_W'(MAX_KEYS)))
    else $error("key index out of range");

  // The final beat of a data set starts work, so loading stops.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_beat.last_item |=> !in_ready)
    else $error("still loading after the final beat");

endmodule

bind optimal_bst_builder obst_checker u_obst_checker (.*);

FILE: sim/optimal_bst_builder_tb.sv
// Self-checking testbench for the optimal BST builder, with a scoreboard class.
module optimal_bst_builder_tb
  import obst_pkg::*;
();

  // The scoreboard predicts the preorder key run and total cost of each data set.
  // It also checks every result beat against the oldest predicted beat.
  class bst_scoreboard;
    bit [31:0]  gap_w [0:MAX_KEYS];
    bit [31:0]  key_w [0:MAX_KEYS];
    int         slot;
    out_beat_t  preorder_q[$];
    int         errors;

    function new();
      slot = 0;
      errors = 0;
    endfunction

    function int pending();
      return preorder_q.size();
    endfunction

    // Runs the interval search over keys 1..n.
    // It then queues the preorder walk of the resulting tree.
    function void build_tree(int n);
      bit [31:0]       wt   [1:MAX_KEYS][1:MAX_KEYS];
      bit [31:0]       ct   [1:MAX_KEYS][1:MAX_KEYS];
      int              rt   [1:MAX_KEYS][1:MAX_KEYS];
      int              lo_s [0:MAX_KEYS+1];
      int              hi_s [0:MAX_KEYS+1];
      longint unsigned best;
      longint unsigned cand;
      int              pick;
      int              j;
      int              sp;
      int              lo;
      int              hi;
      int              r;
      int              emitted;
      bit [31:0]       total;
      out_beat_t       b;
      for (int i = 1; i <= n; i++) begin
        wt[i][i] = gap_w[i-1] + key_w[i] + gap_w[i];
        ct[i][i] = wt[i][i];
        rt[i][i] = i;
      end
      for (int sz = 2; sz <= n; sz++) begin
        for (int i = 1; i + sz - 1 <= n; i++) begin
          j = i + sz - 1;
          best = 64'(INT_MAX);
          pick = 0;
          wt[i][j] = wt[i][j-1] + key_w[j] + gap_w[j];
          for (int k = i; k <= j; k++) begin
            cand = 64'(wt[i][j]);
            if (k > i) cand += 64'(ct[i][k-1]);
            if (k < j) cand += 64'(ct[k+1][j]);
            // A strict comparison keeps the smallest root among equal costs.
            if (cand < best) begin
              best = cand;
              pick = k;
            end
          end
          ct[i][j] = best[31:0];
          rt[i][j] = pick;
        end
      end
      total = ct[1][n];
      emitted = 0;
      sp = 0;
      lo_s[0] = 1;
      hi_s[0] = n;
      sp = 1;
      while (sp > 0) begin
        sp--;
        lo = lo_s[sp];
        hi = hi_s[sp];
        if (lo > hi || lo < 1 || hi > n) continue;
        r = rt[lo][hi];
        // An interval whose minimum was never reached drops out of the walk.
        if (r == 0) continue;
        if (emitted < MAX_KEYS) begin
          b.key_index = KEY_W'(r);
          b.tree_cost = total;
          b.last_result = 1'b0;
          preorder_q.push_back(b);
          emitted++;
        end
        if (sp + 2 <= MAX_KEYS + 2) begin
          lo_s[sp] = r + 1;
          hi_s[sp] = hi;
          sp++;
          lo_s[sp] = lo;
          hi_s[sp] = r - 1;
          sp++;
        end
      end
      if (emitted == 0) begin
        b.key_index = '0;
        b.tree_cost = total;
        b.last_result = 1'b1;
        preorder_q.push_back(b);
      end else begin
        preorder_q[preorder_q.size()-1].last_result = 1'b1;
      end
    endfunction

    // Records one accepted input beat and predicts results when the set closes.
    function void note_beat(in_beat_t beat);
      int  t;
      bit  closes;
      out_beat_t b;
      t = slot;
      closes = beat.last_item;
      gap_w[t] = 32'(beat.dummy_weight & WT_MASK);
      key_w[t] = (t == 0) ? 32'd0 : 32'(beat.key_weight & WT_MASK);
      // Item number MAX_KEYS always closes the set.
      if (t == MAX_KEYS) closes = 1'b1;
      if (!closes) begin
        slot = t + 1;
        return;
      end
      slot = 0;
      if (t == 0) begin
        // An empty set yields one beat with key 0 and cost 0.
        b.key_index = '0;
        b.tree_cost = '0;
        b.last_result = 1'b1;
        preorder_q.push_back(b);
      end else begin
        build_tree(t);
      end
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (preorder_q.size() == 0) begin
        $error("result beat with none expected: key_index %0d tree_cost %0d",
               got.key_index, got.tree_cost);
        errors++;
        return;
      end
      want = preorder_q.pop_front();
      if (got.key_index !== want.key_index) begin
        $error("key_index: expected %0d, actual %0d", want.key_index, got.key_index);
        errors++;
      end
      if (got.tree_cost !== want.tree_cost) begin
        $error("tree_cost: expected %0d, actual %0d", want.tree_cost, got.tree_cost);
        errors++;
      end
      if (got.last_result !== want.last_result) begin
        $error("last_result: expected %0d, actual %0d",
               want.last_result, got.last_result);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_beat;

  bst_scoreboard sb;

  // Idle percentages of the sender and the receiver in the current phase.
  int send_idle_pct;
  int recv_stall_pct;
  // A request from the sender side for a long receiver hold-off.
  int hold_request;
  int items_sent;

  optimal_bst_builder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // The receiver decides out_ready at every edge and checks each accepted beat.
  // Beats are sampled before the edge updates take effect.
  // A hold-off request keeps out_ready low while its hold-off count runs down.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_beat);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offers one beat and waits until the block takes it.
  // in_valid is lowered only when an idle gap is inserted, so it never
  // drops and rises again within the same time step.
  task automatic send_beat(input logic [15:0] dw, input logic [15:0] kw,
                           input logic lst);
    in_beat_t b;
    b.dummy_weight = dw;
    b.key_weight = kw;
    b.last_item = lst;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_beat(b);
    items_sent++;
  endtask

  // Picks a weight with a bias toward the extremes and toward ties.
  function automatic logic [15:0] pick_weight(input int flavor);
    case (flavor)
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'd5;
      default: return 16'($urandom());
    endcase
  endfunction

  // Sends a data set of n keys, items 0..n.
  // At n equal to MAX_KEYS the last flag on the final item is random,
  // because that item closes the set either way.
  task automatic send_set(input int n);
    int flavor;
    flavor = $urandom_range(5);
    for (int t = 0; t <= n; t++) begin
      if (t == MAX_KEYS)
        send_beat(pick_weight(flavor), pick_weight(flavor), 1'($urandom_range(1)));
      else
        send_beat(pick_weight(flavor), pick_weight(flavor), t == n);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int target;
    int idle_tab [4];
    int stall_tab [4];
    int n;
    idle_tab = '{0, 84, 0, 12};
    stall_tab = '{0, 0, 84, 12};
    sb = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 0;
    items_sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_beat = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed sets: an empty set, a single key at full weight, all-zero
    // weights so that every root choice ties, and a set that runs into the
    // key limit without a last flag.
    send_beat(16'hFFFF, 16'hFFFF, 1'b1);
    send_beat(16'hFFFF, 16'h1234, 1'b0);
    send_beat(16'hFFFF, 16'hFFFF, 1'b1);
    for (int t = 0; t <= 3; t++) send_beat(16'h0000, 16'h0000, t == 3);
    for (int t = 0; t <= MAX_KEYS; t++) send_beat(16'hFFFF, 16'hFFFF, 1'b0);
    drain();

    // Random phases with different idling on each side.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      // The receiver holds off at length while sets keep coming, so the
      // block fills and stops taking input.
      if (ph == 2) hold_request = 3000;
      target = items_sent + 45;
      while (items_sent < target) begin
        n = ($urandom_range(19) == 0) ? MAX_KEYS : $urandom_range(8);
        send_set(n);
      end
      // Pause the sender until every expected result beat has arrived.
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("optimal_bst_builder: match");
    end else begin
      if (sb.pending() != 0) $error("%0d result beats never arrived", sb.pending());
      $display("optimal_bst_builder: mismatch");
    end
    $finish;
  end

  // Watchdog for a block that stops making progress.
  initial begin
    #60_000_000;
    $display("optimal_bst_builder: mismatch");
    $finish;
  end

endmodule

FILE: files.f
rtl/obst_pkg.sv
rtl/obst_ram.sv
rtl/obst_dp_unit.sv
rtl/optimal_bst_builder.sv
rtl/obst_checker.sv
sim/optimal_bst_builder_tb.sv
